// ===== hdl/ldq_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked deque package
// Command codes and status codes used by the deque module.
// ----------------------------------------------------------------------------
package ldq_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH_TAIL = 4'd0,
    CMD_PUSH_HEAD = 4'd1,
    CMD_POP_TAIL  = 4'd2,
    CMD_POP_HEAD  = 4'd3,
    CMD_REMOVE    = 4'd4,
    CMD_HEAD      = 4'd5,
    CMD_TAIL      = 4'd6,
    CMD_NEXT      = 4'd7,
    CMD_PREV      = 4'd8,
    CMD_READ      = 4'd9,
    CMD_WRITE     = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_LIVE = 2'd3
  } status_t;

endpackage

// ===== hdl/linked_deque_with_handles.sv =====
// ----------------------------------------------------------------------------
// Linked deque with handles
// Double-ended queue kept as a doubly linked list in a fixed node pool.
// ----------------------------------------------------------------------------
//  channel | ports                                       | handshake
//  input   | in_command, in_node_handle, in_data_in      | start high, busy low
//  result  | out_status, out_handle_out, out_data_out,   | out_valid, one cycle
//          | out_length                                  |
// The result of an item follows its acceptance in state S_EXEC, or in S_FIX
// or S_FIX2 after S_EXEC when a push onto a non-empty deque or an unlink with
// a successor writes the link memories in two steps. The next item is taken
// in S_IDLE after the result, so a new item is not taken before the last one
// is through. The single write port of each link memory sets this. Reset is
// synchronous; free stack entries never written are found by a low-water
// mark. The receiver cannot stall.
module linked_deque_with_handles #(
  parameter int POOL_NODES = 64,
  parameter int DATA_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    in_command,
  input  logic [$clog2(POOL_NODES)-1:0] in_node_handle,
  input  logic [DATA_BITS-1:0]          in_data_in,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [$clog2(POOL_NODES)-1:0] out_handle_out,
  output logic [DATA_BITS-1:0]          out_data_out,
  output logic [$clog2(POOL_NODES):0]   out_length
);

  localparam int AW = $clog2(POOL_NODES);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NONE = LW'(POOL_NODES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_FIX  = 4'b0100,
    S_FIX2 = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cmd_r;
  logic [DATA_BITS-1:0] din_r;
  logic [AW-1:0] node_r;
  logic node_ok_r;
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] free_r, free_nxt, low_r, low_nxt;
  logic [POOL_NODES-1:0] live_r, live_nxt;
  logic [LW-1:0] fix_p_r, fix_p_nxt, fix_x_r, fix_x_nxt;

  logic v_we, n_we, p_we, f_we;
  logic [AW-1:0] v_wa, n_wa, p_wa, f_wa, v_ra, f_ra;
  logic [DATA_BITS-1:0] v_wd, v_rd;
  logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;
  logic [AW-1:0] f_wd, f_rd;

  ldq_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_NODES)) u_val (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  ldq_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_next (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(v_ra), .rdata(n_rd));
  ldq_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_prev (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(v_ra), .rdata(p_rd));
  ldq_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_free (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  logic [AW-1:0] sel_node, push_node;
  logic sel_ok, accept, is_push, is_pop;
  logic [1:0] st;
  logic [AW-1:0] ho;
  logic [DATA_BITS-1:0] dout;
  logic [LW-1:0] lnk;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Node addressed by the command, chosen at accept time.
  always_comb begin
    sel_node = in_node_handle;
    sel_ok   = LW'(in_node_handle) < NONE;
    case (in_command)
      ldq_pkg::CMD_POP_TAIL: begin
        sel_node = tail_r[AW-1:0];
        sel_ok   = tail_r < NONE;
      end
      ldq_pkg::CMD_POP_HEAD: begin
        sel_node = head_r[AW-1:0];
        sel_ok   = head_r < NONE;
      end
      default: ;
    endcase
    sel_ok = sel_ok && live_r[sel_node];
  end

  assign v_ra = busy ? node_r : sel_node;
  // Free stack: entries at or above the low-water mark have been written,
  // entries below it still hold the reset order POOL_NODES-1-i.
  assign f_ra = AW'(free_r - LW'(1));
  assign push_node = (free_r - LW'(1) >= low_r) ? f_rd
                   : AW'(LW'(POOL_NODES - 1) - (free_r - LW'(1)));
  assign is_push = cmd_r == ldq_pkg::CMD_PUSH_TAIL || cmd_r == ldq_pkg::CMD_PUSH_HEAD;
  assign is_pop  = cmd_r == ldq_pkg::CMD_POP_TAIL || cmd_r == ldq_pkg::CMD_POP_HEAD
                || cmd_r == ldq_pkg::CMD_REMOVE;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r;
    free_nxt = free_r; low_nxt = low_r; live_nxt = live_r;
    fix_p_nxt = fix_p_r; fix_x_nxt = fix_x_r;
    v_we = 1'b0; v_wa = node_r; v_wd = din_r;
    n_we = 1'b0; n_wa = node_r; n_wd = NONE;
    p_we = 1'b0; p_wa = node_r; p_wd = NONE;
    f_we = 1'b0; f_wa = AW'(free_r); f_wd = node_r;
    st = ldq_pkg::ST_OK; ho = '0; dout = '0; lnk = NONE;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        out_valid = 1'b1;
        if (is_push) begin
          if (free_r == '0) begin
            st = ldq_pkg::ST_FULL;
          end else begin
            ho = push_node;
            free_nxt = free_r - LW'(1);
            if (free_r - LW'(1) < low_r) low_nxt = free_r - LW'(1);
            live_nxt[push_node] = 1'b1;
            cnt_nxt = cnt_r + LW'(1);
            v_we = 1'b1; v_wa = push_node;
            n_we = 1'b1; n_wa = push_node;
            p_we = 1'b1; p_wa = push_node;
            if (cnt_r == '0) begin
              head_nxt = LW'(push_node); tail_nxt = LW'(push_node);
            end else if (cmd_r == ldq_pkg::CMD_PUSH_HEAD) begin
              n_wd = head_r; head_nxt = LW'(push_node);
              fix_p_nxt = LW'(push_node); fix_x_nxt = head_r;
              state_nxt = S_FIX2;
              out_valid = 1'b0;
            end else begin
              p_wd = tail_r; tail_nxt = LW'(push_node);
              fix_p_nxt = tail_r; fix_x_nxt = LW'(push_node);
              state_nxt = S_FIX2;
              out_valid = 1'b0;
            end
          end
        end else if (is_pop) begin
          if (!node_ok_r) begin
            st = (cmd_r == ldq_pkg::CMD_REMOVE) ? ldq_pkg::ST_NO_LIVE
                                               : ldq_pkg::ST_EMPTY;
          end else begin
            dout = v_rd;
            live_nxt[node_r] = 1'b0;
            if (free_r < LW'(POOL_NODES)) begin
              f_we = 1'b1;
              free_nxt = free_r + LW'(1);
            end
            if (cnt_r != '0) cnt_nxt = cnt_r - LW'(1);
            if (p_rd < NONE) begin
              n_we = 1'b1; n_wa = p_rd[AW-1:0]; n_wd = n_rd;
            end else begin
              head_nxt = n_rd;
            end
            if (n_rd >= NONE) tail_nxt = p_rd;
            fix_p_nxt = p_rd; fix_x_nxt = n_rd;
            if (n_rd < NONE) begin
              state_nxt = S_FIX;
              out_valid = 1'b0;
            end
          end
        end else begin
          case (cmd_r)
            ldq_pkg::CMD_HEAD, ldq_pkg::CMD_TAIL: begin
              lnk = (cmd_r == ldq_pkg::CMD_HEAD) ? head_r : tail_r;
              if (lnk < NONE) ho = lnk[AW-1:0];
              else st = ldq_pkg::ST_EMPTY;
            end
            ldq_pkg::CMD_NEXT, ldq_pkg::CMD_PREV: begin
              lnk = (cmd_r == ldq_pkg::CMD_NEXT) ? n_rd : p_rd;
              if (!node_ok_r) st = ldq_pkg::ST_NO_LIVE;
              else if (lnk < NONE) ho = lnk[AW-1:0];
              else st = ldq_pkg::ST_EMPTY;
            end
            ldq_pkg::CMD_READ, ldq_pkg::CMD_WRITE: begin
              if (!node_ok_r) begin
                st = ldq_pkg::ST_NO_LIVE;
              end else if (cmd_r == ldq_pkg::CMD_WRITE) begin
                v_we = 1'b1; dout = din_r;
              end else begin
                dout = v_rd;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIX: begin
        // Second half of an unlink: previous link of the old successor.
        p_we = 1'b1; p_wa = fix_x_r[AW-1:0]; p_wd = fix_p_r;
        dout = v_rd;
        state_nxt = S_IDLE;
        out_valid = 1'b1;
      end
      S_FIX2: begin
        // Second half of a push: link the old end node to the new one.
        if (cmd_r == ldq_pkg::CMD_PUSH_HEAD) begin
          p_we = 1'b1; p_wa = fix_x_r[AW-1:0]; p_wd = fix_p_r;
          ho = fix_p_r[AW-1:0];
        end else begin
          n_we = 1'b1; n_wa = fix_p_r[AW-1:0]; n_wd = fix_x_r;
          ho = fix_x_r[AW-1:0];
        end
        state_nxt = S_IDLE;
        out_valid = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_status     = st;
  assign out_handle_out = ho;
  assign out_data_out   = dout;
  assign out_length     = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NONE;
      tail_r  <= NONE;
      cnt_r   <= '0;
      free_r  <= LW'(POOL_NODES);
      low_r   <= LW'(POOL_NODES);
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      free_r  <= free_nxt;
      low_r   <= low_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fix_p_r <= fix_p_nxt;
    fix_x_r <= fix_x_nxt;
    if (accept) begin
      cmd_r     <= in_command;
      din_r     <= in_data_in;
      node_r    <= sel_node;
      node_ok_r <= sel_ok;
    end
  end

endmodule

// ===== hdl/ldq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ldq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
